// ----- sv/phbc_pkg.sv -----
// ----------------------------------------------------------------------------
// phbc_pkg
// Shared types and constants for the per host-pair byte counter.
// ----------------------------------------------------------------------------
package phbc_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  // fixed widths of the address, length and result fields
  localparam int SLOT_W  = 6;
  localparam int PAIRS_W = 7;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 16;
  localparam int BYTES_W = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CNT_RD,
    ST_FINISH
  } phbc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input word, restart scan
    logic scan_en;    // step the key scan
    logic take_hit;   // matched entry becomes the slot
    logic take_miss;  // claim next free entry (or flag full)
    logic cnt_rd;     // read counters of the slot
    logic finish;     // write back, load result register
  } phbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic scan_done;
    logic out_free;
  } phbc_status_t;

endpackage

// ----- sv/per_host_pair_byte_counter.sv -----
// ----------------------------------------------------------------------------
// per_host_pair_byte_counter
// Byte counters per (local, remote) address pair, one packet word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_valid/cfg_ready with host_address; always ready. Write
//                  it while the block is idle.
//   in channel   : in_valid/in_ready with source_address, destination_address,
//                  packet_length. One word is in flight at a time.
//   out channel  : out_valid/out_ready, one result word per input word.
// Sequence: entries 0..U-1 are valid (U = pairs in use). The key RAM is
//   scanned one entry per cycle with a registered read, stopping at the
//   first hit or after entry U-1 on a miss (at once when the table is empty).
//   Then a step reads the counter RAMs and a step writes back and loads the
//   result register; the next word is taken in the cycle after write-back.
//   The key scan sets the rate.
// Reset (rst, sync): fill count cleared (the table is empty), host address
//   zero, no result pending. RAM contents are not cleared; the fill count
//   alone marks valid entries.
// Stall: the result register holds while out_ready is low; a finished word
//   waits in the write-back step until the register frees up, and in_ready
//   stays low until then.
// ----------------------------------------------------------------------------
module per_host_pair_byte_counter #(
  parameter int TABLE_ENTRIES = phbc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [phbc_pkg::ADDR_W-1:0]  host_address,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [phbc_pkg::ADDR_W-1:0]  source_address,
  input  logic [phbc_pkg::ADDR_W-1:0]  destination_address,
  input  logic [phbc_pkg::LEN_W-1:0]   packet_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [phbc_pkg::SLOT_W-1:0]  slot_index,
  output logic                         direction_out,
  output logic                         was_created,
  output logic                         table_full,
  output logic [phbc_pkg::BYTES_W-1:0] sent_total,
  output logic [phbc_pkg::BYTES_W-1:0] received_total,
  output logic [phbc_pkg::PAIRS_W-1:0] pairs_in_use
);
  import phbc_pkg::*;

  phbc_cmd_t    cmd;
  phbc_status_t status;

  // config register has no back pressure
  assign cfg_ready = 1'b1;

  phbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  phbc_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_valid           (cfg_valid),
    .host_address        (host_address),
    .source_address      (source_address),
    .destination_address (destination_address),
    .packet_length       (packet_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .slot_index          (slot_index),
    .direction_out       (direction_out),
    .was_created         (was_created),
    .table_full          (table_full),
    .sent_total          (sent_total),
    .received_total      (received_total),
    .pairs_in_use        (pairs_in_use)
  );

endmodule

// ----- sv/phbc_ram.sv -----
// ----------------------------------------------------------------------------
// phbc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module phbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/phbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// phbc_ctrl
// Sequencer: accept, scan keys, read counters, write back and present result.
// ----------------------------------------------------------------------------
module phbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phbc_pkg::phbc_status_t status,
  output phbc_pkg::phbc_cmd_t    cmd
);
  import phbc_pkg::*;

  phbc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.match || status.scan_done) state_next = ST_CNT_RD;
      end
      ST_CNT_RD: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_en   = 1'b1;
        cmd.take_hit  = status.match;
        cmd.take_miss = !status.match && status.scan_done;
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/phbc_datapath.sv -----
// ----------------------------------------------------------------------------
// phbc_datapath
// Key and counter RAMs, scan address, fill count, adders and result register.
// ----------------------------------------------------------------------------
module phbc_datapath #(
  parameter int TABLE_ENTRIES = phbc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  phbc_pkg::phbc_cmd_t                  cmd,
  output phbc_pkg::phbc_status_t               status,
  input  logic                                 cfg_valid,
  input  logic [phbc_pkg::ADDR_W-1:0]          host_address,
  input  logic [phbc_pkg::ADDR_W-1:0]          source_address,
  input  logic [phbc_pkg::ADDR_W-1:0]          destination_address,
  input  logic [phbc_pkg::LEN_W-1:0]           packet_length,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [phbc_pkg::SLOT_W-1:0]          slot_index,
  output logic                                 direction_out,
  output logic                                 was_created,
  output logic                                 table_full,
  output logic [phbc_pkg::BYTES_W-1:0]         sent_total,
  output logic [phbc_pkg::BYTES_W-1:0]         received_total,
  output logic [phbc_pkg::PAIRS_W-1:0]         pairs_in_use
);
  import phbc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W = 2 * ADDR_W;

  // config register
  logic [ADDR_W-1:0] host;

  // latched word
  logic [KEY_W-1:0]  key;
  logic              outgoing;
  logic [LEN_W-1:0]  len;

  // scan
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  scan_addr;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              issue;
  logic [KEY_W-1:0]  key_rd;

  // chosen slot
  logic [IDX_W-1:0]  slot;
  logic              created;
  logic              full;

  logic [BYTES_W-1:0] sent_rd, recv_rd, sent_new, recv_new;
  logic [BYTES_W-1:0] slot_wide, pairs_wide;
  logic [CNT_W-1:0]   used_next;
  logic               do_write;
  logic               src_is_host;

  assign src_is_host = (source_address == host);
  assign issue       = cmd.scan_en && (scan_addr < used_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      host <= '0;
    end else if (cfg_valid) begin
      host <= host_address;
    end
  end

  // latch the packet; key is {local, remote}
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      outgoing <= src_is_host;
      key      <= {host, src_is_host ? destination_address : source_address};
      len      <= packet_length;
    end
  end

  // scan pointer and in-flight read marker
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.accept) begin
      pend <= 1'b0;
    end else if (cmd.scan_en) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_addr <= '0;
    end else if (issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
    end
    if (issue) begin
      pend_idx <= scan_addr[IDX_W-1:0];
    end
  end

  assign status.match     = pend && (key_rd == key);
  assign status.scan_done = cmd.scan_en && !pend && !issue;
  assign status.out_free  = !out_valid || out_ready;

  // slot decision
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      slot    <= pend_idx;
      created <= 1'b0;
      full    <= 1'b0;
    end else if (cmd.take_miss) begin
      slot    <= used_count[IDX_W-1:0];
      created <= 1'b1;
      full    <= (used_count == CNT_W'(TABLE_ENTRIES));
    end
  end

  assign do_write  = cmd.finish && !full;
  assign used_next = used_count + CNT_W'(created);

  // fill count: entries 0..used_count-1 are valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (do_write) begin
      used_count <= used_next;
    end
  end

  phbc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_key_ram (
    .clk     (clk),
    .wr_en   (do_write && created),
    .wr_addr (slot),
    .wr_data (key),
    .rd_en   (issue),
    .rd_addr (scan_addr[IDX_W-1:0]),
    .rd_data (key_rd)
  );

  phbc_ram #(.WIDTH(BYTES_W), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_sent_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (slot),
    .wr_data (sent_new),
    .rd_en   (cmd.cnt_rd),
    .rd_addr (slot),
    .rd_data (sent_rd)
  );

  phbc_ram #(.WIDTH(BYTES_W), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_recv_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (slot),
    .wr_data (recv_new),
    .rd_en   (cmd.cnt_rd),
    .rd_addr (slot),
    .rd_data (recv_rd)
  );

  // new entry starts from zero
  always_comb begin
    sent_new = (created ? '0 : sent_rd) + (outgoing ? BYTES_W'(len) : '0);
    recv_new = (created ? '0 : recv_rd) + (outgoing ? '0 : BYTES_W'(len));
  end

  assign slot_wide  = BYTES_W'(slot);
  assign pairs_wide = full ? BYTES_W'(used_count) : BYTES_W'(used_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      direction_out  <= outgoing;
      table_full     <= full;
      pairs_in_use   <= pairs_wide[PAIRS_W-1:0];
      slot_index     <= full ? '0 : slot_wide[SLOT_W-1:0];
      was_created    <= full ? 1'b0 : created;
      sent_total     <= full ? '0 : sent_new;
      received_total <= full ? '0 : recv_new;
    end
  end

endmodule
